// ===== sv/rgim_pkg.sv =====
// Shared types and constants for the rectilinear grid to image index map.
// Used by the interfaces, the controller, the datapath and the top level.
package rgim_pkg;

   localparam int COORD_W    = 32;
   localparam int CELLS_W    = 11;
   localparam int INDEX_W    = 30;
   localparam int ACT_W      = 2;
   localparam int AXIS_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int SPAN_W     = 34;
   localparam int SPAN_MAG_W = 33;
   localparam int DIV_CNT_W  = 6;
   localparam int CENTER_W   = 36;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 6'd32;
   localparam logic [AXIS_W-1:0]    AXIS_LAST = 2'd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR,
      ACT_APPEND,
      ACT_BUILD,
      ACT_NEXT
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CELLS_X,
      REG_CELLS_Y,
      REG_CELLS_Z,
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_ORIGIN_Z
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AXIS,
      ST_SPAN,
      ST_DIV,
      ST_FIX,
      ST_CELL,
      ST_PREV,
      ST_CUR,
      ST_CMP,
      ST_ZERO,
      ST_NEXT,
      ST_OUT
   } ctl_state_type;

   typedef struct packed {
      logic accept_clear;
      logic accept_append;
      logic accept_next;
      logic build_start;
      logic axis_init;
      logic span_calc;
      logic div_step;
      logic div_fix;
      logic cell_begin;
      logic prev_rd;
      logic cur_rd;
      logic miss_step;
      logic map_write_hit;
      logic map_write_zero;
      logic cell_next;
      logic axis_next;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic start_ge_cnt;
      logic hit;
      logic r_last;
      logic cell_last;
      logic axis_last;
      logic rsp_busy;
   } status_type;

endpackage

// ===== sv/rgim_req_if.sv =====
// Request channel carrying one command beat.
// Depends on rgim_pkg for field widths.
interface rgim_req_if;
   logic                                valid;
   logic                                ready;
   logic [rgim_pkg::ACT_W-1:0]          action;
   logic [rgim_pkg::AXIS_W-1:0]         axis;
   logic signed [rgim_pkg::COORD_W-1:0] bound_value;

   modport source (output valid, output action, output axis, output bound_value, input ready);
   modport sink (input valid, input action, input axis, input bound_value, output ready);
endinterface

// ===== sv/rgim_rsp_if.sv =====
// Response channel carrying one grid cell index beat.
// Depends on rgim_pkg for field widths.
interface rgim_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rgim_pkg::INDEX_W-1:0] grid_cell_index;
   logic                         last_cell;

   modport source (output valid, output grid_cell_index, output last_cell, input ready);
   modport sink (input valid, input grid_cell_index, input last_cell, output ready);
endinterface

// ===== sv/rgim_ctrl.sv =====
// Controller state machine for the grid to image index map.
// Depends on rgim_pkg and rgim_req_if; drives the datapath by commands.
module rgim_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   rgim_req_if.sink               req,
   input  rgim_pkg::status_type   status,
   output rgim_pkg::cmd_type      cmd
);

   rgim_pkg::ctl_state_type state_ff;
   rgim_pkg::ctl_state_type state_in;
   logic                    accept;

   assign req.ready = (state_ff == rgim_pkg::ST_IDLE) && !status.rsp_busy;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgim_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rgim_pkg::ST_IDLE: begin
            if (accept) begin
               if (rgim_pkg::action_type'(req.action) == rgim_pkg::ACT_BUILD) begin
                  state_in = rgim_pkg::ST_AXIS;
               end else if (rgim_pkg::action_type'(req.action) == rgim_pkg::ACT_NEXT) begin
                  state_in = rgim_pkg::ST_OUT;
               end
            end
         end
         rgim_pkg::ST_AXIS: state_in = rgim_pkg::ST_SPAN;
         rgim_pkg::ST_SPAN: state_in = rgim_pkg::ST_DIV;
         rgim_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = rgim_pkg::ST_FIX;
            end
         end
         rgim_pkg::ST_FIX: state_in = rgim_pkg::ST_CELL;
         rgim_pkg::ST_CELL: begin
            state_in = status.start_ge_cnt ? rgim_pkg::ST_ZERO : rgim_pkg::ST_PREV;
         end
         rgim_pkg::ST_PREV: state_in = rgim_pkg::ST_CUR;
         rgim_pkg::ST_CUR: state_in = rgim_pkg::ST_CMP;
         rgim_pkg::ST_CMP: begin
            if (status.hit) begin
               state_in = rgim_pkg::ST_NEXT;
            end else if (status.r_last) begin
               state_in = rgim_pkg::ST_ZERO;
            end else begin
               state_in = rgim_pkg::ST_CUR;
            end
         end
         rgim_pkg::ST_ZERO: state_in = rgim_pkg::ST_NEXT;
         rgim_pkg::ST_NEXT: begin
            if (!status.cell_last) begin
               state_in = rgim_pkg::ST_CELL;
            end else if (!status.axis_last) begin
               state_in = rgim_pkg::ST_AXIS;
            end else begin
               state_in = rgim_pkg::ST_IDLE;
            end
         end
         rgim_pkg::ST_OUT: state_in = rgim_pkg::ST_IDLE;
         default: state_in = rgim_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         rgim_pkg::ST_IDLE: begin
            if (accept) begin
               case (rgim_pkg::action_type'(req.action))
                  rgim_pkg::ACT_CLEAR:  cmd.accept_clear  = 1'b1;
                  rgim_pkg::ACT_APPEND: cmd.accept_append = 1'b1;
                  rgim_pkg::ACT_BUILD:  cmd.build_start   = 1'b1;
                  rgim_pkg::ACT_NEXT:   cmd.accept_next   = 1'b1;
                  default:              cmd = '0;
               endcase
            end
         end
         rgim_pkg::ST_AXIS: cmd.axis_init  = 1'b1;
         rgim_pkg::ST_SPAN: cmd.span_calc  = 1'b1;
         rgim_pkg::ST_DIV:  cmd.div_step   = 1'b1;
         rgim_pkg::ST_FIX:  cmd.div_fix    = 1'b1;
         rgim_pkg::ST_CELL: cmd.cell_begin = 1'b1;
         rgim_pkg::ST_PREV: cmd.prev_rd    = 1'b1;
         rgim_pkg::ST_CUR:  cmd.cur_rd     = 1'b1;
         rgim_pkg::ST_CMP: begin
            if (status.hit) begin
               cmd.map_write_hit = 1'b1;
            end else begin
               cmd.miss_step = 1'b1;
            end
         end
         rgim_pkg::ST_ZERO: cmd.map_write_zero = 1'b1;
         rgim_pkg::ST_NEXT: begin
            if (!status.cell_last) begin
               cmd.cell_next = 1'b1;
            end else if (!status.axis_last) begin
               cmd.axis_next = 1'b1;
            end
         end
         rgim_pkg::ST_OUT: cmd.out_load = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== sv/rgim_datapath.sv =====
// Datapath of the grid to image index map: bound and map memories, the
// centre divider and stepper, search pointers and the output register.
// Depends on rgim_pkg and rgim_rsp_if; commanded by rgim_ctrl.
module rgim_datapath #(
   parameter int MAX_BOUNDS      = 1025,
   parameter int MAX_IMAGE_CELLS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rgim_pkg::cmd_type                     cmd,
   output rgim_pkg::status_type                  status,
   input  logic [rgim_pkg::AXIS_W-1:0]           req_axis,
   input  logic signed [rgim_pkg::COORD_W-1:0]   req_bound_value,
   input  logic                                  csr_we,
   input  logic [rgim_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rgim_pkg::COORD_W-1:0]          csr_data,
   rgim_rsp_if.source                            rsp
);

   localparam int CW  = $clog2(MAX_BOUNDS + 1);
   localparam int RW  = $clog2(MAX_BOUNDS);
   localparam int DW  = $clog2(MAX_IMAGE_CELLS + 1);
   localparam int PW  = (MAX_IMAGE_CELLS > 1) ? $clog2(MAX_IMAGE_CELLS) : 1;
   localparam int BAW = $clog2(3 * MAX_BOUNDS);
   localparam int VW  = DW + 2;
   localparam int IW  = rgim_pkg::INDEX_W;
   localparam int QW  = rgim_pkg::CENTER_W;
   localparam int MW  = rgim_pkg::SPAN_MAG_W;

   logic [rgim_pkg::CELLS_W-1:0]        cells_ff  [3];
   logic signed [rgim_pkg::COORD_W-1:0] origin_ff [3];
   logic [CW-1:0]                       count_ff  [3];
   logic [PW-1:0]                       pos_ff    [3];
   logic [DW-1:0]                       dim_ff    [3];

   logic [rgim_pkg::AXIS_W-1:0] a_ff;
   logic [PW-1:0]               i_ff;
   logic [CW-1:0]               start_ff;
   logic [CW-1:0]               r_ff;

   logic signed [rgim_pkg::COORD_W-1:0] bt_mem [3 * MAX_BOUNDS];
   logic signed [rgim_pkg::COORD_W-1:0] bt_rd_ff;
   logic signed [rgim_pkg::COORD_W-1:0] prev_ff;

   logic                             neg_ff;
   logic [MW-1:0]                    mag_ff;
   logic [VW-1:0]                    drem_ff;
   logic [rgim_pkg::DIV_CNT_W-1:0]   dcnt_ff;
   logic signed [QW-1:0]             q_ff;
   logic signed [QW-1:0]             qs_ff;
   logic [VW-1:0]                    racc_ff;
   logic [VW-1:0]                    rs_ff;

   logic [IW-1:0] gg_ff;
   logic          last_pend_ff;
   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_index_ff;
   logic          rsp_last_ff;

   logic [CW-1:0]                       cnt_a;
   logic [DW-1:0]                       dim_a;
   logic signed [rgim_pkg::COORD_W-1:0] origin_a;
   logic [VW-1:0]                       divisor;
   logic [BAW-1:0]                      axis_base;
   logic [BAW-1:0]                      bt_rd_addr;
   logic                                bt_rd_en;
   logic [BAW-1:0]                      bt_wr_addr;
   logic                                bt_we;
   logic signed [rgim_pkg::SPAN_W-1:0]  span;
   logic [VW-1:0]                       trial;
   logic                                trial_ge;
   logic                                rem_nz;
   logic signed [QW-1:0]                q0;
   logic [VW-1:0]                       r0;
   logic [VW-1:0]                       r2;
   logic                                r2_ge;
   logic [VW-1:0]                       t_sum;
   logic                                t_ge;
   logic signed [QW-1:0]                center;
   logic [CW-1:0]                       g     [3];
   logic [RW-1:0]                       map_rd [3];
   logic                                map_we;
   logic [RW-1:0]                       map_wdata;
   logic                                wrap0, wrap1, wrap2;
   logic [IW-1:0]                       index_sum;

   assign cnt_a    = count_ff[a_ff];
   assign dim_a    = dim_ff[a_ff];
   assign origin_a = origin_ff[a_ff];
   assign divisor  = VW'({dim_a, 1'b0});
   assign axis_base = BAW'(a_ff) * BAW'(MAX_BOUNDS);

   always_comb begin
      bt_rd_en   = 1'b0;
      bt_rd_addr = axis_base + BAW'(r_ff);
      if (cmd.axis_init) begin
         bt_rd_en   = (cnt_a != '0);
         bt_rd_addr = axis_base + BAW'(cnt_a - CW'(1));
      end else if (cmd.prev_rd) begin
         bt_rd_en   = 1'b1;
         bt_rd_addr = axis_base + BAW'(r_ff - CW'(1));
      end else if (cmd.cur_rd) begin
         bt_rd_en   = 1'b1;
      end
   end

   assign bt_we      = cmd.accept_append && (req_axis <= rgim_pkg::AXIS_LAST) &&
                       (32'(count_ff[req_axis[1:0]]) < 32'(MAX_BOUNDS));
   assign bt_wr_addr = BAW'(req_axis) * BAW'(MAX_BOUNDS) + BAW'(count_ff[req_axis[1:0]]);

   always_ff @(posedge clock) begin
      if (bt_we) begin
         bt_mem[bt_wr_addr] <= req_bound_value;
      end
      if (bt_rd_en) begin
         bt_rd_ff <= bt_mem[bt_rd_addr];
      end
   end

   assign span     = (cnt_a == '0) ? '0 :
                     rgim_pkg::SPAN_W'(bt_rd_ff) - rgim_pkg::SPAN_W'(origin_a);
   assign trial    = {drem_ff[VW-2:0], mag_ff[MW-1]};
   assign trial_ge = (trial >= divisor);
   assign rem_nz   = (drem_ff != '0);

   always_comb begin
      q0 = $signed({{(QW - MW){1'b0}}, mag_ff});
      r0 = drem_ff;
      if (neg_ff) begin
         q0 = -q0 - QW'(rem_nz);
         if (rem_nz) begin
            r0 = divisor - drem_ff;
         end
      end
   end

   assign r2     = {r0[VW-2:0], 1'b0};
   assign r2_ge  = (r2 >= divisor);
   assign t_sum  = racc_ff + rs_ff;
   assign t_ge   = (t_sum >= divisor);
   assign center = QW'(origin_a) + q_ff;

   always_ff @(posedge clock) begin
      if (cmd.cur_rd) begin
         prev_ff <= bt_rd_ff;
      end
      if (cmd.span_calc) begin
         neg_ff  <= span[rgim_pkg::SPAN_W-1];
         mag_ff  <= MW'(span[rgim_pkg::SPAN_W-1] ? -span : span);
         drem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         drem_ff <= trial_ge ? trial - divisor : trial;
         mag_ff  <= {mag_ff[MW-2:0], trial_ge};
         dcnt_ff <= dcnt_ff + rgim_pkg::DIV_CNT_W'(1);
      end
      if (cmd.div_fix) begin
         q_ff    <= q0;
         racc_ff <= r0;
         qs_ff   <= (q0 <<< 1) + QW'(r2_ge);
         rs_ff   <= r2_ge ? r2 - divisor : r2;
      end else if (cmd.cell_next) begin
         racc_ff <= t_ge ? t_sum - divisor : t_sum;
         q_ff    <= q_ff + qs_ff + QW'(t_ge);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= '0;
         i_ff     <= '0;
         start_ff <= CW'(1);
         r_ff     <= '0;
      end else begin
         if (cmd.build_start) begin
            a_ff <= '0;
         end else if (cmd.axis_next) begin
            a_ff <= a_ff + rgim_pkg::AXIS_W'(1);
         end
         if (cmd.axis_init) begin
            start_ff <= CW'(1);
            i_ff     <= '0;
         end else begin
            if (cmd.map_write_hit) begin
               start_ff <= r_ff;
            end
            if (cmd.cell_next) begin
               i_ff <= i_ff + PW'(1);
            end
         end
         if (cmd.cell_begin) begin
            r_ff <= start_ff;
         end else if (cmd.miss_step) begin
            r_ff <= r_ff + CW'(1);
         end
      end
   end

   assign map_we    = cmd.map_write_hit || cmd.map_write_zero;
   assign map_wdata = cmd.map_write_hit ? RW'(r_ff - CW'(1)) : '0;

   for (genvar k = 0; k < 3; k++) begin : g_map
      logic [RW-1:0] map_mem [MAX_IMAGE_CELLS];
      logic [RW-1:0] rd_ff;
      always_ff @(posedge clock) begin
         if (map_we && (a_ff == rgim_pkg::AXIS_W'(k))) begin
            map_mem[i_ff] <= map_wdata;
         end
         if (cmd.accept_next) begin
            rd_ff <= map_mem[pos_ff[k]];
         end
      end
      assign map_rd[k] = rd_ff;
      assign g[k]      = (count_ff[k] == '0) ? '0 : count_ff[k] - CW'(1);
   end

   assign wrap0 = ({1'b0, DW'(pos_ff[0])} + (DW + 1)'(1)) == {1'b0, dim_ff[0]};
   assign wrap1 = ({1'b0, DW'(pos_ff[1])} + (DW + 1)'(1)) == {1'b0, dim_ff[1]};
   assign wrap2 = ({1'b0, DW'(pos_ff[2])} + (DW + 1)'(1)) == {1'b0, dim_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            cells_ff[k]  <= rgim_pkg::CELLS_W'(1);
            origin_ff[k] <= '0;
            count_ff[k]  <= '0;
            pos_ff[k]    <= '0;
            dim_ff[k]    <= DW'(1);
         end
      end else begin
         if (csr_we) begin
            case (rgim_pkg::csr_index_type'(csr_index))
               rgim_pkg::REG_CELLS_X:  cells_ff[0]  <= csr_data[rgim_pkg::CELLS_W-1:0];
               rgim_pkg::REG_CELLS_Y:  cells_ff[1]  <= csr_data[rgim_pkg::CELLS_W-1:0];
               rgim_pkg::REG_CELLS_Z:  cells_ff[2]  <= csr_data[rgim_pkg::CELLS_W-1:0];
               rgim_pkg::REG_ORIGIN_X: origin_ff[0] <= $signed(csr_data);
               rgim_pkg::REG_ORIGIN_Y: origin_ff[1] <= $signed(csr_data);
               rgim_pkg::REG_ORIGIN_Z: origin_ff[2] <= $signed(csr_data);
               default: ;
            endcase
         end
         if (cmd.accept_clear) begin
            for (int k = 0; k < 3; k++) begin
               count_ff[k] <= '0;
               pos_ff[k]   <= '0;
            end
         end
         if (bt_we) begin
            count_ff[req_axis[1:0]] <= count_ff[req_axis[1:0]] + CW'(1);
         end
         if (cmd.build_start) begin
            for (int k = 0; k < 3; k++) begin
               pos_ff[k] <= '0;
               if (cells_ff[k] == '0) begin
                  dim_ff[k] <= DW'(1);
               end else if (32'(cells_ff[k]) > 32'(MAX_IMAGE_CELLS)) begin
                  dim_ff[k] <= DW'(MAX_IMAGE_CELLS);
               end else begin
                  dim_ff[k] <= DW'(cells_ff[k]);
               end
            end
         end
         if (cmd.accept_next) begin
            pos_ff[0] <= wrap0 ? '0 : pos_ff[0] + PW'(1);
            if (wrap0) begin
               pos_ff[1] <= wrap1 ? '0 : pos_ff[1] + PW'(1);
               if (wrap1) begin
                  pos_ff[2] <= wrap2 ? '0 : pos_ff[2] + PW'(1);
               end
            end
         end
      end
   end

   assign index_sum = gg_ff * IW'(map_rd[2]) + IW'(g[0]) * IW'(map_rd[1]) + IW'(map_rd[0]);

   always_ff @(posedge clock) begin
      gg_ff <= IW'(g[0]) * IW'(g[1]);
      if (cmd.accept_next) begin
         last_pend_ff <= wrap0 && wrap1 && wrap2;
      end
      if (cmd.out_load) begin
         rsp_index_ff <= index_sum;
         rsp_last_ff  <= last_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.grid_cell_index = rsp_index_ff;
   assign rsp.last_cell       = rsp_last_ff;

   assign status.div_done     = (dcnt_ff == rgim_pkg::DIV_LAST);
   assign status.start_ge_cnt = (start_ff >= cnt_a);
   assign status.hit          = (center > QW'(prev_ff)) && (center <= QW'(bt_rd_ff));
   assign status.r_last       = ({1'b0, r_ff} + (CW + 1)'(1)) >= {1'b0, cnt_a};
   assign status.cell_last    = ({1'b0, DW'(i_ff)} + (DW + 1)'(1)) == {1'b0, dim_a};
   assign status.axis_last    = (a_ff == rgim_pkg::AXIS_LAST);
   assign status.rsp_busy     = rsp_valid_ff && !rsp.ready;

endmodule

// ===== sv/rect_grid_to_image_index_map.sv =====
// Top level of the rectilinear grid to image index map.
// Depends on rgim_pkg, rgim_req_if, rgim_rsp_if, rgim_ctrl and rgim_datapath.
//
// Clear and append beats are handled in the idle state. For a next-cell beat the three
// axis map memories are read first and the index multiply-add then fills the output
// register; no new beat is taken while a previous result waits unaccepted at the
// output. A build beat walks the three axes in turn; each axis does the span read and
// the 33-step serial divider, then per image cell a forward-only search that reads the
// previous bound and compares bounds in turn, and writes a zero map entry when it
// finds none or has no bound left to compare.
module rect_grid_to_image_index_map #(
   parameter int MAX_BOUNDS      = 1025,
   parameter int MAX_IMAGE_CELLS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   rgim_req_if.sink                        req_beat,
   rgim_rsp_if.source                      rsp_beat,
   input  logic                            csr_we,
   input  logic [rgim_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgim_pkg::COORD_W-1:0]    csr_data
);

   rgim_pkg::cmd_type    cmd;
   rgim_pkg::status_type status;

   rgim_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_beat),
      .status (status),
      .cmd    (cmd)
   );

   rgim_datapath #(
      .MAX_BOUNDS      (MAX_BOUNDS),
      .MAX_IMAGE_CELLS (MAX_IMAGE_CELLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_axis        (req_beat.axis),
      .req_bound_value (req_beat.bound_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp             (rsp_beat)
   );

endmodule
